// ===== hw/rtl/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// checked on every edge outside reset
`define THM_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked on every edge, reset included
`define THM_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== hw/rtl/thm_pkg.sv =====
package thm_pkg;

   localparam int NUM_SLOTS = 256;
   localparam int MAX_SHOWN = 8;
   localparam int SLOT_W    = $clog2(NUM_SLOTS);
   localparam int SCAN_W    = SLOT_W + 1;
   localparam int SHOWN_W   = $clog2(MAX_SHOWN + 1);
   localparam int BUF_W     = (MAX_SHOWN > 1) ? $clog2(MAX_SHOWN) : 1;
   localparam int Q_DEPTH   = 2;
   localparam int QPTR_W    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
   localparam int QCNT_W    = $clog2(Q_DEPTH + 1);
   localparam int CSR_IDX_W = 2;

   localparam logic [7:0] RUN_MAX = 8'hFF;
   localparam logic [7:0] THRESHOLD_RST = 8'd2;
   localparam logic [7:0] LIMIT_RST     = 8'd16;

   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_LIMIT     = 2'd1;

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_DONE   = 2'd1,
      OP_TICK   = 2'd2,
      OP_NONE   = 2'd3
   } op_type;

   typedef enum logic {
      CMD_RECORD = 1'b0,
      CMD_TICK   = 1'b1
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type kind;
      logic [30:0]  tid;
      logic [1:0]   act_kind;
      logic [31:0]  code;
   } cmd_type;

   typedef struct packed {
      logic [30:0] owner;
      logic [1:0]  kind;
      logic [31:0] code;
      logic [31:0] events;
      logic [1:0]  seen_kind;
      logic [31:0] seen_code;
      logic [31:0] seen_events;
      logic        seen_valid;
      logic [7:0]  run;
   } row_type;

   typedef struct packed {
      logic [30:0] thread;
      logic [1:0]  kind;
      logic [31:0] code;
      logic [31:0] events;
      logic [7:0]  quiet;
   } shown_type;

   typedef struct packed {
      logic                  cmd_vld;
      cmd_type               cmd;
      logic [QCNT_W-1:0]     q_cnt;
   } front_stat_type;

   typedef struct packed {
      logic clearing;
      logic pop;
   } back_stat_type;

endpackage

// ===== hw/rtl/thm_if.sv =====
interface thm_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  operation;
   logic [30:0] thread_id;
   logic [1:0]  activity_kind;
   logic [31:0] activity_code;
   modport source (output valid, operation, thread_id, activity_kind, activity_code,
                   input ready);
   modport sink   (input valid, operation, thread_id, activity_kind, activity_code,
                   output ready);
endinterface

interface thm_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] stuck_thread;
   logic [1:0]  stuck_kind;
   logic [31:0] stuck_code;
   logic [31:0] event_total;
   logic [7:0]  quiet_ticks;
   logic [7:0]  report_number;
   logic        last_entry;
   modport source (output valid, stuck_thread, stuck_kind, stuck_code, event_total,
                   quiet_ticks, report_number, last_entry, input ready);
   modport sink   (input valid, stuck_thread, stuck_kind, stuck_code, event_total,
                   quiet_ticks, report_number, last_entry, output ready);
endinterface

interface thm_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/thm_front.sv =====
module thm_front (
   input  logic                   clock,
   input  logic                   reset,
   thm_req_if.sink                req_chan,
   input  thm_pkg::back_stat_type back_stat,
   output thm_pkg::front_stat_type front_stat
);
   import thm_pkg::*;

   cmd_type           q_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              accept, push, keep;
   cmd_type           cmd_new;

   assign req_chan.ready = !back_stat.clearing && (cnt_ff != QCNT_W'(Q_DEPTH));
   assign accept = req_chan.valid && req_chan.ready;

   // done items and ignored operations are taken and dropped here
   always_comb begin
      unique case (op_type'(req_chan.operation))
         OP_RECORD: keep = (req_chan.thread_id != '0);
         OP_TICK:   keep = 1'b1;
         OP_DONE:   keep = 1'b0;
         default:   keep = 1'b0;
      endcase
      cmd_new.kind     = (op_type'(req_chan.operation) == OP_TICK) ? CMD_TICK : CMD_RECORD;
      cmd_new.tid      = req_chan.thread_id;
      cmd_new.act_kind = req_chan.activity_kind;
      cmd_new.code     = req_chan.activity_code;
   end

   assign push = accept && keep;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (back_stat.pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !back_stat.pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!push && back_stat.pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= cmd_new;
      end
   end

   assign front_stat.cmd_vld = (cnt_ff != '0);
   assign front_stat.cmd     = q_ff[rd_ptr_ff];
   assign front_stat.q_cnt   = cnt_ff;

endmodule

// ===== hw/rtl/thm_back.sv =====
module thm_back (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [7:0]              threshold,
   input  logic [7:0]              limit,
   input  thm_pkg::front_stat_type front_stat,
   output thm_pkg::back_stat_type  back_stat,
   thm_rsp_if.source               rsp_chan
);
   import thm_pkg::*;

   typedef enum logic [5:0] {
      ST_CLEAR = 6'b000001,
      ST_IDLE  = 6'b000010,
      ST_SCAN  = 6'b000100,
      ST_STORE = 6'b001000,
      ST_TICK  = 6'b010000,
      ST_EMIT  = 6'b100000
   } state_type;

   row_type mem [NUM_SLOTS];
   row_type rd_row_ff;
   logic [SLOT_W-1:0] rd_addr, wr_addr;
   logic              wr_en;
   row_type           wr_row;

   state_type          state_ff, state_in;
   logic [SCAN_W-1:0]  scan_ff, scan_in;
   logic               eval_vld_ff, eval_vld_in;
   logic [SLOT_W-1:0]  eval_idx_ff, eval_idx_in;
   cmd_type            cmd_ff, cmd_in;
   logic               found_ff, found_in;
   logic [SLOT_W-1:0]  found_idx_ff, found_idx_in;
   row_type            found_row_ff, found_row_in;
   logic               free_ff, free_in;
   logic [SLOT_W-1:0]  free_idx_ff, free_idx_in;
   row_type            free_row_ff, free_row_in;
   logic               pick_en_ff, pick_en_in;
   logic [SHOWN_W-1:0] shown_ff, shown_in;
   logic [SHOWN_W-1:0] emit_ff, emit_in;
   logic [7:0]         reports_ff, reports_in;
   shown_type          pick_ff [MAX_SHOWN];
   logic               pick_wr;
   shown_type          pick_new;

   logic               rsp_vld_ff, rsp_vld_in, rsp_load;
   shown_type          rsp_ff;
   logic [7:0]         rsp_num_ff;
   logic               rsp_last_ff, last_now;

   row_type            cur, upd;
   logic               same;
   logic [7:0]         run_new;

   // tick update of the slot under evaluation
   always_comb begin
      cur  = rd_row_ff;
      same = cur.seen_valid && (cur.seen_kind == cur.kind) &&
             (cur.seen_code == cur.code) && (cur.seen_events == cur.events);
      if (!same) begin
         run_new = '0;
      end else if (cur.run == RUN_MAX) begin
         run_new = RUN_MAX;
      end else begin
         run_new = cur.run + 8'd1;
      end
      upd             = cur;
      upd.seen_kind   = cur.kind;
      upd.seen_code   = cur.code;
      upd.seen_events = cur.events;
      upd.seen_valid  = 1'b1;
      upd.run         = run_new;
      pick_new.thread = cur.owner;
      pick_new.kind   = cur.kind;
      pick_new.code   = cur.code;
      pick_new.events = cur.events;
      pick_new.quiet  = run_new;
   end

   assign last_now = (emit_ff == shown_ff - SHOWN_W'(1));
   assign rsp_load = (state_ff == ST_EMIT) && (!rsp_vld_ff || rsp_chan.ready);

   always_comb begin
      state_in     = state_ff;
      scan_in      = scan_ff;
      eval_vld_in  = 1'b0;
      eval_idx_in  = eval_idx_ff;
      cmd_in       = cmd_ff;
      found_in     = found_ff;
      found_idx_in = found_idx_ff;
      found_row_in = found_row_ff;
      free_in      = free_ff;
      free_idx_in  = free_idx_ff;
      free_row_in  = free_row_ff;
      pick_en_in   = pick_en_ff;
      shown_in     = shown_ff;
      emit_in      = emit_ff;
      reports_in   = reports_ff;
      rd_addr      = scan_ff[SLOT_W-1:0];
      wr_en        = 1'b0;
      wr_addr      = eval_idx_ff;
      wr_row       = upd;
      pick_wr      = 1'b0;
      back_stat.pop      = 1'b0;
      back_stat.clearing = (state_ff == ST_CLEAR);
      rsp_vld_in   = rsp_vld_ff && !rsp_chan.ready;

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = scan_ff[SLOT_W-1:0];
            wr_row  = '0;
            scan_in = scan_ff + 1'b1;
            if (scan_ff == SCAN_W'(NUM_SLOTS - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (front_stat.cmd_vld) begin
               back_stat.pop = 1'b1;
               cmd_in     = front_stat.cmd;
               scan_in    = '0;
               found_in   = 1'b0;
               free_in    = 1'b0;
               shown_in   = '0;
               pick_en_in = (reports_ff < limit);
               state_in   = (front_stat.cmd.kind == CMD_TICK) ? ST_TICK : ST_SCAN;
            end
         end
         ST_SCAN, ST_TICK: begin
            if (scan_ff != SCAN_W'(NUM_SLOTS)) begin
               eval_vld_in = 1'b1;
               eval_idx_in = scan_ff[SLOT_W-1:0];
               scan_in     = scan_ff + 1'b1;
            end
            if (eval_vld_ff && state_ff == ST_SCAN) begin
               if (cur.owner == cmd_ff.tid) begin
                  found_in     = 1'b1;
                  found_idx_in = eval_idx_ff;
                  found_row_in = cur;
               end else if (cur.owner == '0 && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = eval_idx_ff;
                  free_row_in = cur;
               end
            end
            if (eval_vld_ff && state_ff == ST_TICK && cur.owner != '0) begin
               wr_en = 1'b1;
               if (pick_en_ff && run_new >= threshold &&
                   shown_ff != SHOWN_W'(MAX_SHOWN)) begin
                  pick_wr  = 1'b1;
                  shown_in = shown_ff + 1'b1;
               end
            end
            if (scan_ff == SCAN_W'(NUM_SLOTS) && !eval_vld_ff) begin
               if (state_ff == ST_SCAN) begin
                  state_in = ST_STORE;
               end else if (shown_ff != '0) begin
                  reports_in = (reports_ff == RUN_MAX) ? RUN_MAX : reports_ff + 8'd1;
                  emit_in    = '0;
                  state_in   = ST_EMIT;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_STORE: begin
            // existing owner wins over a free slot; a full table drops the item
            if (found_ff) begin
               wr_en         = 1'b1;
               wr_addr       = found_idx_ff;
               wr_row        = found_row_ff;
               wr_row.events = found_row_ff.events + 32'd1;
            end else begin
               wr_en         = free_ff;
               wr_addr       = free_idx_ff;
               wr_row        = free_row_ff;
               wr_row.owner  = cmd_ff.tid;
               wr_row.events = 32'd1;
            end
            wr_row.kind = cmd_ff.act_kind;
            wr_row.code = cmd_ff.code;
            state_in    = ST_IDLE;
         end
         ST_EMIT: begin
            if (rsp_load) begin
               rsp_vld_in = 1'b1;
               emit_in    = emit_ff + 1'b1;
               if (last_now) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_row;
      end
      rd_row_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         scan_ff     <= '0;
         eval_vld_ff <= 1'b0;
         reports_ff  <= '0;
         rsp_vld_ff  <= 1'b0;
      end else begin
         state_ff    <= state_in;
         scan_ff     <= scan_in;
         eval_vld_ff <= eval_vld_in;
         reports_ff  <= reports_in;
         rsp_vld_ff  <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      eval_idx_ff  <= eval_idx_in;
      cmd_ff       <= cmd_in;
      found_ff     <= found_in;
      found_idx_ff <= found_idx_in;
      found_row_ff <= found_row_in;
      free_ff      <= free_in;
      free_idx_ff  <= free_idx_in;
      free_row_ff  <= free_row_in;
      pick_en_ff   <= pick_en_in;
      shown_ff     <= shown_in;
      emit_ff      <= emit_in;
      if (pick_wr) begin
         pick_ff[shown_ff[BUF_W-1:0]] <= pick_new;
      end
      if (rsp_load) begin
         rsp_ff      <= pick_ff[emit_ff[BUF_W-1:0]];
         rsp_num_ff  <= reports_ff;
         rsp_last_ff <= last_now;
      end
   end

   assign rsp_chan.valid         = rsp_vld_ff;
   assign rsp_chan.stuck_thread  = rsp_ff.thread;
   assign rsp_chan.stuck_kind    = rsp_ff.kind;
   assign rsp_chan.stuck_code    = rsp_ff.code;
   assign rsp_chan.event_total   = rsp_ff.events;
   assign rsp_chan.quiet_ticks   = rsp_ff.quiet;
   assign rsp_chan.report_number = rsp_num_ff;
   assign rsp_chan.last_entry    = rsp_last_ff;

endmodule

// ===== hw/rtl/thread_hang_monitor_unit.sv =====
// channel  direction  content
// req      in         operation, thread_id, activity_kind, activity_code
// rsp      out        one stuck entry per picked slot, last_entry on the final one
// csr      in         index 0 stuck_threshold, index 1 report_limit
//
// a tick walks the slot table through one memory read port, one slot a cycle,
// then emits one entry per slot picked. a record walks the table the same way,
// then writes the slot back. done and ignored items are taken and never reach the table walk.
// after reset a clearing pass runs over every slot, req is held off meanwhile.
// a two-deep command queue sits ahead of the walker; an rsp stall holds the emitter
// and so the walker, and once the queue fills it holds off req as well.
`include "assert_macros.svh"

module thread_hang_monitor_unit (
   input  logic    clock,
   input  logic    reset,
   thm_req_if.sink req_chan,
   thm_rsp_if.source rsp_chan,
   thm_csr_if.sink csr_chan
);
   import thm_pkg::*;

   logic [7:0]     threshold_ff, limit_ff;
   front_stat_type front_stat;
   back_stat_type  back_stat;

   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RST;
         limit_ff     <= LIMIT_RST;
      end else if (csr_chan.valid) begin
         unique case (csr_chan.index)
            CSR_THRESHOLD: threshold_ff <= csr_chan.data;
            CSR_LIMIT:     limit_ff     <= csr_chan.data;
            default: ;
         endcase
      end
   end

   thm_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .back_stat  (back_stat),
      .front_stat (front_stat)
   );

   thm_back u_back (
      .clock      (clock),
      .reset      (reset),
      .threshold  (threshold_ff),
      .limit      (limit_ff),
      .front_stat (front_stat),
      .back_stat  (back_stat),
      .rsp_chan   (rsp_chan)
   );

   `THM_ASSERT(a_clear_blocks_req, back_stat.clearing |-> !req_chan.ready, "req during clear")
   `THM_ASSERT(a_queue_bound, front_stat.q_cnt <= QCNT_W'(Q_DEPTH), "command queue overrun")
   `THM_ASSERT(a_pop_needs_cmd, back_stat.pop |-> front_stat.cmd_vld, "pop from empty queue")
   `THM_ASSERT(a_report_nonzero, rsp_chan.valid |-> rsp_chan.report_number != 8'd0, "report zero")
   `THM_ASSERT_ALWAYS(a_rsp_idle_after_reset, $past(reset) |-> !rsp_chan.valid, "rsp after reset")

endmodule
